// ===== rtl/source_text_tokenizer_defines.svh =====
// Assertion macros shared by the source text tokenizer RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition holds in the same cycle as the trigger
`define STT_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tokenizer assertion failed");

// Condition holds in the cycle after the trigger
`define STT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tokenizer assertion failed");

`else

`define STT_ASSERT_IMPLY(label, clk, rst, pre, post)
`define STT_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// ===== rtl/stt_pkg.sv =====
// Shared types, codes and helpers for the source text tokenizer.
// No dependencies; the front end, queue, serializer and top module import this package.
package stt_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT   = 4;
   localparam int MAX_TOKENS            = 3;

   // Scanner modes
   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_OP,
      MODE_SLASH,
      MODE_COMMENT,
      MODE_STRING,
      MODE_NUMBER,
      MODE_NUMDOT,
      MODE_FRAC,
      MODE_DONE
   } scan_mode_type;

   // Token kinds
   localparam logic [4:0] K_LPAREN  = 5'd0;
   localparam logic [4:0] K_RPAREN  = 5'd1;
   localparam logic [4:0] K_LBRACE  = 5'd2;
   localparam logic [4:0] K_RBRACE  = 5'd3;
   localparam logic [4:0] K_COMMA   = 5'd4;
   localparam logic [4:0] K_DOT     = 5'd5;
   localparam logic [4:0] K_MINUS   = 5'd6;
   localparam logic [4:0] K_PLUS    = 5'd7;
   localparam logic [4:0] K_SEMI    = 5'd8;
   localparam logic [4:0] K_SLASH   = 5'd9;
   localparam logic [4:0] K_STAR    = 5'd10;
   localparam logic [4:0] K_BANG    = 5'd11;
   localparam logic [4:0] K_EQUAL   = 5'd13;
   localparam logic [4:0] K_GREATER = 5'd15;
   localparam logic [4:0] K_LESS    = 5'd17;
   localparam logic [4:0] K_STRING  = 5'd19;
   localparam logic [4:0] K_NUMBER  = 5'd20;
   localparam logic [4:0] K_EOF     = 5'd21;

   // Error codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_STRING = 2'd1;
   localparam logic [1:0] ERR_CHAR   = 2'd2;

   // Character codes
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_GREATER = 8'h3E;
   localparam logic [7:0] CH_LESS    = 8'h3C;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   localparam logic [15:0] LINE_MAX = 16'hFFFF;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] lex_start;
      logic [15:0] lex_end;
      logic [1:0]  err;
   } token_type;

   // All results caused by one input byte
   typedef struct packed {
      token_type [MAX_TOKENS-1:0] tok;
      logic [15:0]                line;
      logic [1:0]                 count;
   } bundle_type;

   function automatic token_type make_token(logic [4:0] kind, logic [15:0] lex_start,
                                            logic [15:0] lex_end, logic [1:0] err);
      token_type t;
      t.kind      = kind;
      t.lex_start = lex_start;
      t.lex_end   = lex_end;
      t.err       = err;
      return t;
   endfunction

   function automatic logic is_numeral_byte(logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

endpackage

// ===== rtl/stt_req_if.sv =====
// Source byte channel of the tokenizer: valid/ready plus one byte and the end flag.
// No dependencies.
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_marker;

   modport source (output valid, text_byte, end_marker, input ready);
   modport sink   (input valid, text_byte, end_marker, output ready);
endinterface

// ===== rtl/stt_rsp_if.sv =====
// Token channel of the tokenizer: valid/ready plus one token result.
// No dependencies.
interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [15:0] lexeme_start;
   logic [15:0] lexeme_end;
   logic [15:0] line_number;
   logic [1:0]  error_code;
   logic        last_of_run;

   modport source (output valid, token_kind, lexeme_start, lexeme_end, line_number,
                   error_code, last_of_run, input ready);
   modport sink   (input valid, token_kind, lexeme_start, lexeme_end, line_number,
                   error_code, last_of_run, output ready);
endinterface

// ===== rtl/stt_front.sv =====
// Scanner front end: takes one byte per cycle while push_ready is high, keeps lookahead
// state, builds a bundle of up to three tokens. Depends on stt_pkg, stt_req_if, defines.
`include "source_text_tokenizer_defines.svh"

module stt_front #(
   parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   stt_req_if.sink             req_ch,
   output logic                push_valid,
   input  logic                push_ready,
   output stt_pkg::bundle_type push_data
);
   import stt_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   scan_mode_type            mode_ff, mode_in;
   logic [4:0]               pend_ff, pend_in;
   logic [POSITION_BITS-1:0] begin_ff, begin_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [15:0]              line_ff, line_in;
   logic                     halted_ff, halted_in;

   logic [POSITION_BITS-1:0] p, np, dp;
   logic [7:0]               b;
   logic                     fire;
   logic                     fresh;
   logic [1:0]               n;
   token_type [MAX_TOKENS-1:0] slot;

   assign req_ch.ready = push_ready;

   // Hold scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pend_ff   <= '0;
         begin_ff  <= '0;
         pos_ff    <= '0;
         line_ff   <= 16'd1;
         halted_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         begin_ff  <= begin_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         halted_ff <= halted_in;
      end
   end

   // Classify the byte and collect the tokens it finishes
   always_comb begin
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      begin_in  = begin_ff;
      pos_in    = pos_ff;
      line_in   = line_ff;
      halted_in = halted_ff;
      fresh     = 1'b0;
      n         = 2'd0;
      slot      = '0;
      b         = req_ch.text_byte;
      p         = pos_ff;
      np        = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
      dp        = (pos_ff != '0) ? pos_ff - 1'b1 : '0;
      fire      = req_ch.valid && push_ready && !halted_ff && (mode_ff != MODE_DONE);

      if (fire && req_ch.end_marker) begin
         // Flush any pending token, then close with end of file (an open string gives an error token instead)
         unique case (mode_ff)
            MODE_OP: begin
               slot[n] = make_token(pend_ff, 16'(begin_ff), 16'(p), ERR_NONE);
               n = n + 2'd1;
            end
            MODE_SLASH: begin
               slot[n] = make_token(K_SLASH, 16'(begin_ff), 16'(p), ERR_NONE);
               n = n + 2'd1;
            end
            MODE_NUMBER, MODE_FRAC: begin
               slot[n] = make_token(K_NUMBER, 16'(begin_ff), 16'(p), ERR_NONE);
               n = n + 2'd1;
            end
            MODE_NUMDOT: begin
               slot[n] = make_token(K_NUMBER, 16'(begin_ff), 16'(dp), ERR_NONE);
               n = n + 2'd1;
               slot[n] = make_token(K_DOT, 16'(dp), 16'(p), ERR_NONE);
               n = n + 2'd1;
            end
            default: ;
         endcase
         if (mode_ff == MODE_STRING) begin
            slot[n]   = make_token(K_LPAREN, 16'(begin_ff), 16'(p), ERR_STRING);
            n         = n + 2'd1;
            halted_in = 1'b1;
            mode_in   = MODE_IDLE;
         end else begin
            slot[n] = make_token(K_EOF, 16'(p), 16'(p), ERR_NONE);
            n       = n + 2'd1;
            mode_in = MODE_DONE;
         end
      end else if (fire) begin
         pos_in = np;
         // Resolve lookahead held from earlier bytes
         unique case (mode_ff)
            MODE_OP: begin
               mode_in = MODE_IDLE;
               if (b == CH_EQUAL) begin
                  slot[n] = make_token(5'(pend_ff + 5'd1), 16'(begin_ff), 16'(np), ERR_NONE);
                  n = n + 2'd1;
               end else begin
                  slot[n] = make_token(pend_ff, 16'(begin_ff), 16'(p), ERR_NONE);
                  n = n + 2'd1;
                  fresh = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (b == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  mode_in = MODE_IDLE;
                  slot[n] = make_token(K_SLASH, 16'(begin_ff), 16'(p), ERR_NONE);
                  n = n + 2'd1;
                  fresh = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (b == CH_NEWLINE) begin
                  mode_in = MODE_IDLE;
                  fresh   = 1'b1;
               end
            end
            MODE_STRING: begin
               if (b == CH_QUOTE) begin
                  mode_in = MODE_IDLE;
                  slot[n] = make_token(K_STRING, 16'(begin_ff), 16'(np), ERR_NONE);
                  n = n + 2'd1;
               end
            end
            MODE_NUMBER: begin
               if (b == CH_DOT) begin
                  mode_in = MODE_NUMDOT;
               end else if (!is_numeral_byte(b)) begin
                  mode_in = MODE_IDLE;
                  slot[n] = make_token(K_NUMBER, 16'(begin_ff), 16'(p), ERR_NONE);
                  n = n + 2'd1;
                  fresh = 1'b1;
               end
            end
            MODE_NUMDOT: begin
               if (is_numeral_byte(b)) begin
                  mode_in = MODE_FRAC;
               end else begin
                  mode_in = MODE_IDLE;
                  slot[n] = make_token(K_NUMBER, 16'(begin_ff), 16'(dp), ERR_NONE);
                  n = n + 2'd1;
                  slot[n] = make_token(K_DOT, 16'(dp), 16'(p), ERR_NONE);
                  n = n + 2'd1;
                  fresh = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (!is_numeral_byte(b)) begin
                  mode_in = MODE_IDLE;
                  slot[n] = make_token(K_NUMBER, 16'(begin_ff), 16'(p), ERR_NONE);
                  n = n + 2'd1;
                  fresh = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               fresh   = 1'b1;
            end
         endcase

         // Start a new lexeme at this byte
         if (fresh) begin
            begin_in = p;
            case (b) inside
               CH_LPAREN: begin
                  slot[n] = make_token(K_LPAREN, 16'(p), 16'(np), ERR_NONE);
                  n = n + 2'd1;
               end
               CH_RPAREN: begin
                  slot[n] = make_token(K_RPAREN, 16'(p), 16'(np), ERR_NONE);
                  n = n + 2'd1;
               end
               CH_LBRACE: begin
                  slot[n] = make_token(K_LBRACE, 16'(p), 16'(np), ERR_NONE);
                  n = n + 2'd1;
               end
               CH_RBRACE: begin
                  slot[n] = make_token(K_RBRACE, 16'(p), 16'(np), ERR_NONE);
                  n = n + 2'd1;
               end
               CH_COMMA: begin
                  slot[n] = make_token(K_COMMA, 16'(p), 16'(np), ERR_NONE);
                  n = n + 2'd1;
               end
               CH_DOT: begin
                  slot[n] = make_token(K_DOT, 16'(p), 16'(np), ERR_NONE);
                  n = n + 2'd1;
               end
               CH_MINUS: begin
                  slot[n] = make_token(K_MINUS, 16'(p), 16'(np), ERR_NONE);
                  n = n + 2'd1;
               end
               CH_PLUS: begin
                  slot[n] = make_token(K_PLUS, 16'(p), 16'(np), ERR_NONE);
                  n = n + 2'd1;
               end
               CH_SEMI: begin
                  slot[n] = make_token(K_SEMI, 16'(p), 16'(np), ERR_NONE);
                  n = n + 2'd1;
               end
               CH_STAR: begin
                  slot[n] = make_token(K_STAR, 16'(p), 16'(np), ERR_NONE);
                  n = n + 2'd1;
               end
               CH_BANG: begin
                  mode_in = MODE_OP;
                  pend_in = K_BANG;
               end
               CH_EQUAL: begin
                  mode_in = MODE_OP;
                  pend_in = K_EQUAL;
               end
               CH_GREATER: begin
                  mode_in = MODE_OP;
                  pend_in = K_GREATER;
               end
               CH_LESS: begin
                  mode_in = MODE_OP;
                  pend_in = K_LESS;
               end
               CH_SLASH: mode_in = MODE_SLASH;
               CH_SPACE, CH_CR, CH_TAB: ;
               CH_NEWLINE: begin
                  if (line_ff != LINE_MAX) line_in = line_ff + 16'd1;
               end
               CH_QUOTE: mode_in = MODE_STRING;
               default: begin
                  if (is_numeral_byte(b)) begin
                     mode_in = MODE_NUMBER;
                  end else begin
                     slot[n]   = make_token(K_LPAREN, 16'(p), 16'(np), ERR_CHAR);
                     n         = n + 2'd1;
                     halted_in = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   assign push_valid      = fire && (n != 2'd0);
   assign push_data.tok   = slot;
   assign push_data.line  = line_ff;
   assign push_data.count = n;

   `STT_ASSERT_IMPLY(a_front_halt_quiet, clock, reset, halted_ff, !push_valid)
   `STT_ASSERT_IMPLY(a_front_done_quiet, clock, reset, mode_ff == MODE_DONE, !push_valid)

endmodule

// ===== rtl/stt_queue.sv =====
// Short bundle queue between the scanner and the token serializer.
// Depends on stt_pkg and the defines header.
`include "source_text_tokenizer_defines.svh"

module stt_queue #(
   parameter int DEPTH = stt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  stt_pkg::bundle_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output stt_pkg::bundle_type pop_data
);
   import stt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   bundle_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire, pop_fire;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop_fire)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push_fire && !pop_fire)      count_in = count_ff + 1'b1;
      else if (!push_fire && pop_fire) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store bundles; payload needs no reset
   always_ff @(posedge clock) begin
      if (push_fire) entry_ff[wr_ptr_ff] <= push_data;
   end

   `STT_ASSERT_IMPLY(a_queue_bound, clock, reset, 1'b1, count_ff <= CNT_FULL)
   `STT_ASSERT_NEXT(a_queue_grow, clock, reset, push_fire && !pop_fire, count_ff == $past(count_ff) + 1'b1)

endmodule

// ===== rtl/stt_back.sv =====
// Token serializer: walks the head bundle and presents one token per transaction.
// Depends on stt_pkg, stt_rsp_if and the defines header.
`include "source_text_tokenizer_defines.svh"

module stt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  stt_pkg::bundle_type head_data,
   output logic                head_pop,
   stt_rsp_if.source           rsp_ch
);
   import stt_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       fire;
   token_type  cur;

   assign cur  = head_data.tok[idx_ff];
   assign last = (idx_ff == head_data.count - 2'd1);
   assign fire = rsp_ch.valid && rsp_ch.ready;

   assign rsp_ch.valid        = head_valid;
   assign rsp_ch.token_kind   = cur.kind;
   assign rsp_ch.lexeme_start = cur.lex_start;
   assign rsp_ch.lexeme_end   = cur.lex_end;
   assign rsp_ch.line_number  = head_data.line;
   assign rsp_ch.error_code   = cur.err;
   assign rsp_ch.last_of_run  = last;
   assign head_pop            = fire && last;

   // Step through the bundle; drop it after its last token
   always_comb begin
      idx_in = idx_ff;
      if (fire) idx_in = last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 2'd0;
      else       idx_ff <= idx_in;
   end

   `STT_ASSERT_IMPLY(a_back_idx_bound, clock, reset, head_valid, idx_ff < head_data.count)
   `STT_ASSERT_NEXT(a_back_idx_step, clock, reset, fire && !last, idx_ff == $past(idx_ff) + 2'd1)

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// Source text tokenizer: takes one byte per cycle; tokens wait in the registered queue.
// A byte that finishes k tokens (k up to 3) emits them one per rsp_ch transfer. Bytes flow
// at one per cycle while the bundle queue (QUEUE_DEPTH entries) has room and stall once it
// is full, so a long run of multi-token bytes or a stalled sink paces the input.
// Reset is synchronous, active high: position 0, line 1, scanner idle, queue empty.
// After an error token or end of file the block takes bytes and emits nothing until reset.
module source_text_tokenizer #(
   parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT,
   parameter int QUEUE_DEPTH   = stt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   stt_req_if.sink    req_ch,
   stt_rsp_if.source  rsp_ch
);
   import stt_pkg::*;

   logic       push_valid, push_ready;
   bundle_type push_data;
   logic       head_valid, head_pop;
   bundle_type head_data;

   stt_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   stt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (head_valid),
      .pop_ready  (head_pop),
      .pop_data   (head_data)
   );

   stt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
